// ===== sv/butterworth_lowpass_8th_cascade_defines.svh =====
// Assertion macros for the filter RTL (used by bwlp8_ctrl).
// Both macros sample on clk and are disabled while rst is high.
`ifndef BUTTERWORTH_LOWPASS_8TH_CASCADE_DEFINES_SVH
`define BUTTERWORTH_LOWPASS_8TH_CASCADE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define BLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define BLP_ASSERT_IMP(lbl, ante, cons)
`define BLP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/bwlp8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bwlp8_pkg;

  localparam int SECTIONS     = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int FUNC_W       = 3;
  localparam int DATA_W       = 32;
  localparam int W_W          = 32;
  localparam int HIST_W       = 41;
  localparam int COEF_W       = 22;
  localparam int OMSQ_W       = 21;
  localparam int LIN_W        = 20;
  localparam int PROD_W       = 66;
  localparam int NUM_W        = 64;
  localparam int QUO_W        = 48;
  localparam int SEC_W        = 2;
  localparam int POLE_W       = 31;
  localparam int SSQ_W        = 32;

  localparam logic [FUNC_W-1:0] FUNC_INIT = '0;

  localparam logic [COEF_W-1:0] Q16_ONE = COEF_W'(65536);
  localparam logic [COEF_W-1:0] Q16_TWO = COEF_W'(131072);

  // pole pair (cj, ck) per section, Q30
  localparam logic [POLE_W-1:0] POLE_Q30 [2*SECTIONS] = '{
    31'd209476615, 31'd1053110197, 31'd596538960, 31'd892783685,
    31'd892783685, 31'd596538960, 31'd1053110197, 31'd209476615
  };

  // cj*cj + ck*ck rounded into Q30
  function automatic logic [SSQ_W-1:0] ssq_q30(input int s);
    longint unsigned cj;
    longint unsigned ck;
    longint unsigned sum;
    cj  = longint'(POLE_Q30[2*s]);
    ck  = longint'(POLE_Q30[2*s+1]);
    sum = cj * cj + ck * ck + (64'd1 << 29);
    return SSQ_W'(sum >> 30);
  endfunction

  localparam logic [SSQ_W-1:0] SSQ_Q30 [SECTIONS] = '{
    ssq_q30(0), ssq_q30(1), ssq_q30(2), ssq_q30(3)
  };

  typedef enum logic [3:0] {
    DP_NOP       = 4'd0,
    DP_LOAD      = 4'd1,
    DP_W2        = 4'd2,
    DP_W2_STORE  = 4'd3,
    DP_LIN       = 4'd4,
    DP_LIN_STORE = 4'd5,
    DP_QUAD      = 4'd6,
    DP_COEF      = 4'd7,
    DP_HREAD     = 4'd8,
    DP_MUL1      = 4'd9,
    DP_MUL2      = 4'd10,
    DP_SUM       = 4'd11,
    DP_WB        = 4'd12,
    DP_OUT       = 4'd13
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [SEC_W-1:0] sec;
  } dp_cmd_t;

  typedef struct packed {
    logic is_init;
    logic is_filt;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== sv/butterworth_lowpass_8th_cascade.sv =====
// Channel   Handshake               Payload (low bit up)
// s_*       s_tvalid / s_tready     s_tuser: func[2:0]; s_tdata: sample[31:0]
// m_*       m_tvalid / m_tready     m_tdata: filtered[31:0]
// cfg_*     cfg_we (no wait)        cfg_wdata: omega_t[31:0]
//
// Filter beat: each of the four sections reads its history, forms the two filter products
// and starts the divider, waits on the radix-2 divider, then writes back. Init beat: w*w,
// then the linear, quadratic and coefficient steps for each section.
// Reset (rst, synchronous) clears history valid bits and restores A=1, B=2, w*w=0.
// Input is taken only when idle; a finished result waits in the output register
// while the next beat is accepted, so m_tready low stalls only the following result.
`timescale 1ns / 1ps
`default_nettype none
module butterworth_lowpass_8th_cascade #(
  parameter int CHANNELS = bwlp8_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [bwlp8_pkg::DATA_W-1:0]      s_tdata,   // [31:0] sample
  input  wire logic [bwlp8_pkg::FUNC_W-1:0]      s_tuser,   // [2:0] func
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [bwlp8_pkg::DATA_W-1:0]           m_tdata,   // [31:0] filtered
  input  wire logic                              cfg_we,
  input  wire logic [bwlp8_pkg::W_W-1:0]         cfg_wdata
);

  // command and status between sequencer and datapath
  bwlp8_pkg::dp_cmd_t cmd;
  bwlp8_pkg::dp_sts_t sts;

  // sequencer: walks init steps or the four sections of one sample
  bwlp8_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: coefficient and filter multipliers, divider, history memory, coefficients
  bwlp8_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func_in   (s_tuser),
    .sample_in (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .filtered  (m_tdata)
  );

endmodule
`default_nettype wire

// ===== sv/bwlp8_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bwlp8_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [bwlp8_pkg::NUM_W-1:0]   num,
  input  wire logic        [bwlp8_pkg::COEF_W-1:0]  den,
  output logic                                      done,
  output logic signed [bwlp8_pkg::QUO_W:0]          quot
);

  localparam int QW = bwlp8_pkg::QUO_W;
  localparam int CW = bwlp8_pkg::COEF_W;
  localparam int NW = bwlp8_pkg::NUM_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CW-1:0]    rem;
  logic [QW-1:0]    mq;
  logic [CW-1:0]    dq;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  logic [NW-1:0]    mag;
  logic [CW:0]      trial;
  logic             qbit;
  logic [CW-1:0]    rem_next;

  // the top bits of the magnitude are already below den (den >= 1.0 in Q16)
  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_comb begin
    trial = {rem, mq[QW-1]};
    qbit  = (trial >= {1'b0, dq});
    rem_next = qbit ? CW'(trial - {1'b0, dq}) : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'(mag[NW-1:QW]);
      mq  <= mag[QW-1:0];
      dq  <= den;
      neg <= num[NW-1];
    end else if (busy) begin
      rem <= rem_next;
      mq  <= {mq[QW-2:0], qbit};
    end
  end

  assign quot = neg ? -$signed({1'b0, mq}) : $signed({1'b0, mq});

endmodule
`default_nettype wire

// ===== sv/bwlp8_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bwlp8_dp #(
  parameter int CHANNELS = bwlp8_pkg::CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bwlp8_pkg::dp_cmd_t                  cmd,
  output bwlp8_pkg::dp_sts_t                       sts,
  input  wire logic [bwlp8_pkg::FUNC_W-1:0]        func_in,
  input  wire logic [bwlp8_pkg::DATA_W-1:0]        sample_in,
  input  wire logic                                cfg_we,
  input  wire logic [bwlp8_pkg::W_W-1:0]           cfg_wdata,
  output logic [bwlp8_pkg::DATA_W-1:0]             filtered
);

  localparam int HW    = bwlp8_pkg::HIST_W;
  localparam int CW    = bwlp8_pkg::COEF_W;
  localparam int PW    = bwlp8_pkg::PROD_W;
  localparam int ROWS  = CHANNELS * bwlp8_pkg::SECTIONS;
  localparam int ROW_W = $clog2(ROWS);

  logic [bwlp8_pkg::W_W-1:0]    omega_t;
  logic [bwlp8_pkg::OMSQ_W-1:0] omega_sq;
  logic [bwlp8_pkg::LIN_W-1:0]  lin2;
  logic [CW-1:0]                coef_a [bwlp8_pkg::SECTIONS];
  logic [CW-1:0]                coef_b [bwlp8_pkg::SECTIONS];
  logic [bwlp8_pkg::FUNC_W-1:0] func_q;
  logic signed [HW-1:0]         y;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         acc;

  logic [2*HW-1:0]              hist_mem [ROWS];
  logic [ROWS-1:0]              hvalid;
  logic [2*HW-1:0]              hist_rd;
  logic                         hv_rd;
  logic [ROW_W-1:0]             row_q;
  logic [ROW_W-1:0]             row_c;

  logic signed [32:0]           ma;
  logic signed [32:0]           mb;
  logic signed [65:0]           mprod;
  logic signed [41:0]           fa;
  logic signed [22:0]           fb;
  logic signed [64:0]           fprod;
  logic signed [HW-1:0]         h0;
  logic signed [HW-1:0]         h1;
  logic signed [PW-1:0]         h1_sh;
  logic signed [PW-1:0]         num_c;
  logic [21:0]                  w2_rnd;
  logic [62:0]                  lin_sum;
  logic [52:0]                  quad_sum;
  logic [22:0]                  quad;
  logic signed [bwlp8_pkg::QUO_W:0] quot;
  logic                         div_done;
  logic signed [HW-1:0]         r_clamp;
  logic                         q_over;
  logic                         q_under;
  logic                         filt_in;
  logic [bwlp8_pkg::DATA_W-1:0] y_sat;

  assign filt_in = (func_in != bwlp8_pkg::FUNC_INIT) && (int'(func_in) <= CHANNELS);
  assign sts.is_init  = (func_q == bwlp8_pkg::FUNC_INIT);
  assign sts.is_filt  = (func_q != bwlp8_pkg::FUNC_INIT) && (int'(func_q) <= CHANNELS);
  assign sts.div_done = div_done;

  assign row_c = ROW_W'(int'(cmd.sec) + bwlp8_pkg::SECTIONS * (int'(func_q) - 1));

  assign h0 = hv_rd ? $signed(hist_rd[HW-1:0])    : '0;
  assign h1 = hv_rd ? $signed(hist_rd[2*HW-1:HW]) : '0;

  // operand select: coefficient multiplier for init, filter multiplier for sections
  always_comb begin
    ma = '0;
    mb = '0;
    fa = '0;
    fb = '0;
    case (cmd.op)
      bwlp8_pkg::DP_W2: begin
        ma = $signed({1'b0, omega_t});
        mb = $signed({1'b0, omega_t});
      end
      bwlp8_pkg::DP_LIN: begin
        ma = $signed({1'b0, omega_t});
        mb = $signed({2'b0, bwlp8_pkg::POLE_Q30[2*int'(cmd.sec)]});
      end
      bwlp8_pkg::DP_QUAD: begin
        ma = $signed({1'b0, bwlp8_pkg::SSQ_Q30[cmd.sec]});
        mb = $signed({12'b0, omega_sq});
      end
      bwlp8_pkg::DP_MUL1: begin
        fa = 42'(y);
        fb = $signed({2'b0, omega_sq});
      end
      bwlp8_pkg::DP_MUL2: begin
        fa = 42'(h0);
        fb = $signed({1'b0, coef_b[cmd.sec]});
      end
      default: begin
        ma = '0;
        mb = '0;
        fa = '0;
        fb = '0;
      end
    endcase
  end

  assign mprod = ma * mb;
  assign fprod = fa * fb;

  always_comb begin
    w2_rnd   = {1'b0, prod[63:43]} + 22'd1;
    lin_sum  = prod[62:0] + (63'd1 << 42);
    quad_sum = prod[52:0] + (53'd1 << 29);
    quad     = quad_sum[52:30];
    h1_sh    = {{(PW-HW-16){h1[HW-1]}}, h1, 16'b0};
    num_c    = acc + prod - h1_sh;
  end

  bwlp8_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == bwlp8_pkg::DP_SUM),
    .num   (num_c[bwlp8_pkg::NUM_W-1:0]),
    .den   (coef_a[cmd.sec]),
    .done  (div_done),
    .quot  (quot)
  );

  // clamp the quotient into the history range
  always_comb begin
    q_over  = !quot[bwlp8_pkg::QUO_W] && (|quot[bwlp8_pkg::QUO_W-1:HW-1]);
    q_under = quot[bwlp8_pkg::QUO_W] && !(&quot[bwlp8_pkg::QUO_W-1:HW-1]);
    if (q_over) begin
      r_clamp = {1'b0, {(HW-1){1'b1}}};
    end else if (q_under) begin
      r_clamp = {1'b1, {(HW-1){1'b0}}};
    end else begin
      r_clamp = quot[HW-1:0];
    end
  end

  always_comb begin
    if (!y[HW-1] && (|y[HW-2:31])) begin
      y_sat = 32'h7FFF_FFFF;
    end else if (y[HW-1] && !(&y[HW-2:31])) begin
      y_sat = 32'h8000_0000;
    end else begin
      y_sat = y[31:0];
    end
  end

  // control-side state: config, coefficients, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      omega_t  <= '0;
      omega_sq <= '0;
      hvalid   <= '0;
      for (int i = 0; i < bwlp8_pkg::SECTIONS; i++) begin
        coef_a[i] <= bwlp8_pkg::Q16_ONE;
        coef_b[i] <= bwlp8_pkg::Q16_TWO;
      end
    end else begin
      if (cfg_we) begin
        omega_t <= cfg_wdata;
      end
      case (cmd.op)
        bwlp8_pkg::DP_W2:       hvalid <= '0;
        bwlp8_pkg::DP_W2_STORE: omega_sq <= w2_rnd[21:1];
        bwlp8_pkg::DP_COEF: begin
          coef_a[cmd.sec] <= CW'(bwlp8_pkg::Q16_ONE + CW'(lin2) + CW'(quad));
          coef_b[cmd.sec] <= CW'(bwlp8_pkg::Q16_TWO + CW'(lin2));
        end
        bwlp8_pkg::DP_WB:       hvalid[row_q] <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      bwlp8_pkg::DP_LOAD: begin
        func_q <= func_in;
        y <= filt_in ? HW'($signed(sample_in)) : '0;
      end
      bwlp8_pkg::DP_W2, bwlp8_pkg::DP_LIN, bwlp8_pkg::DP_QUAD: prod <= mprod;
      bwlp8_pkg::DP_MUL1: prod <= PW'(fprod);
      bwlp8_pkg::DP_MUL2: begin
        acc  <= prod;
        prod <= PW'(fprod);
      end
      bwlp8_pkg::DP_LIN_STORE: lin2 <= lin_sum[62:43];
      bwlp8_pkg::DP_HREAD: begin
        row_q   <= row_c;
        hist_rd <= hist_mem[row_c];
        hv_rd   <= hvalid[row_c];
      end
      bwlp8_pkg::DP_WB: begin
        hist_mem[row_q] <= {h0, r_clamp};
        y <= r_clamp;
      end
      bwlp8_pkg::DP_OUT: filtered <= y_sat;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/bwlp8_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "butterworth_lowpass_8th_cascade_defines.svh"
module bwlp8_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output bwlp8_pkg::dp_cmd_t       cmd,
  input  wire bwlp8_pkg::dp_sts_t  sts
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_DISPATCH = 15'h0002,
    S_I_W2     = 15'h0004,
    S_I_W2S    = 15'h0008,
    S_I_LIN    = 15'h0010,
    S_I_LINS   = 15'h0020,
    S_I_QUAD   = 15'h0040,
    S_I_COEF   = 15'h0080,
    S_F_READ   = 15'h0100,
    S_F_MUL1   = 15'h0200,
    S_F_MUL2   = 15'h0400,
    S_F_SUM    = 15'h0800,
    S_F_DIV    = 15'h1000,
    S_F_WB     = 15'h2000,
    S_RESULT   = 15'h4000
  } state_t;

  localparam logic [bwlp8_pkg::SEC_W-1:0] SEC_LAST =
    bwlp8_pkg::SEC_W'(bwlp8_pkg::SECTIONS - 1);

  state_t                        state;
  state_t                        state_next;
  logic [bwlp8_pkg::SEC_W-1:0]   sec;
  logic [bwlp8_pkg::SEC_W-1:0]   sec_next;
  bwlp8_pkg::dp_op_t             op;

  assign s_tready = (state == S_IDLE);
  assign cmd.op   = op;
  assign cmd.sec  = sec;

  always_comb begin
    state_next = state;
    sec_next   = sec;
    op         = bwlp8_pkg::DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op = bwlp8_pkg::DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        sec_next = '0;
        if (sts.is_init) begin
          state_next = S_I_W2;
        end else if (sts.is_filt) begin
          state_next = S_F_READ;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_I_W2: begin
        op = bwlp8_pkg::DP_W2;
        state_next = S_I_W2S;
      end
      S_I_W2S: begin
        op = bwlp8_pkg::DP_W2_STORE;
        state_next = S_I_LIN;
      end
      S_I_LIN: begin
        op = bwlp8_pkg::DP_LIN;
        state_next = S_I_LINS;
      end
      S_I_LINS: begin
        op = bwlp8_pkg::DP_LIN_STORE;
        state_next = S_I_QUAD;
      end
      S_I_QUAD: begin
        op = bwlp8_pkg::DP_QUAD;
        state_next = S_I_COEF;
      end
      S_I_COEF: begin
        op = bwlp8_pkg::DP_COEF;
        if (sec == SEC_LAST) begin
          state_next = S_RESULT;
        end else begin
          sec_next = sec + 1'b1;
          state_next = S_I_LIN;
        end
      end
      S_F_READ: begin
        op = bwlp8_pkg::DP_HREAD;
        state_next = S_F_MUL1;
      end
      S_F_MUL1: begin
        op = bwlp8_pkg::DP_MUL1;
        state_next = S_F_MUL2;
      end
      S_F_MUL2: begin
        op = bwlp8_pkg::DP_MUL2;
        state_next = S_F_SUM;
      end
      S_F_SUM: begin
        op = bwlp8_pkg::DP_SUM;
        state_next = S_F_DIV;
      end
      S_F_DIV: begin
        if (sts.div_done) begin
          state_next = S_F_WB;
        end
      end
      S_F_WB: begin
        op = bwlp8_pkg::DP_WB;
        if (sec == SEC_LAST) begin
          state_next = S_RESULT;
        end else begin
          sec_next = sec + 1'b1;
          state_next = S_F_READ;
        end
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          op = bwlp8_pkg::DP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sec      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      sec   <= sec_next;
      if (op == bwlp8_pkg::DP_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `BLP_ASSERT_IMP(a_wb_after_div, state == S_F_WB, $past(state) == S_F_DIV)
  `BLP_ASSERT_NXT(a_out_sets_valid, op == bwlp8_pkg::DP_OUT, m_tvalid)
  `BLP_ASSERT_NXT(a_div_leaves_on_done, state == S_F_DIV && sts.div_done, state == S_F_WB)

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int N_CH       = 4;
  localparam int N_SEC      = 4;
  localparam int WDOG_LIMIT = 20000;
  // long enough to cover any filter beat still in flight
  localparam int DRAIN_WAIT = 300;
  localparam logic [2:0] FN_UNUSED_LO = 3'd5;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;
  localparam longint HIST_HI = 64'sd1099511627775;
  localparam longint HIST_LO = -64'sd1099511627776;
  localparam longint unsigned ONE_Q16 = 64'd65536;

  // pole pairs (cj, ck) per section, Q30
  localparam longint unsigned POLES [8] = '{
    64'd209476615, 64'd1053110197, 64'd596538960, 64'd892783685,
    64'd892783685, 64'd596538960, 64'd1053110197, 64'd209476615
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] sample
  logic [2:0]  s_tuser;   // [2:0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] filtered
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // shadow copy of the filter state
  logic [31:0]     cutoff_reg;
  longint          hist_y [N_CH*N_SEC*2];
  longint unsigned coef_a [N_SEC];
  longint unsigned coef_b [N_SEC];
  longint unsigned w_sq;

  logic [31:0] filtered_q [$];
  int  errors;
  bit  calm;          // no random idling on either side while set (a requested hold-off still applies)
  int  hold_req;      // bumped by a test to ask for a long receiver hold-off
  int  hold_len;
  int  wdog;

  butterworth_lowpass_8th_cascade uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint clip_hist(longint v);
    if (v > HIST_HI) return HIST_HI;
    if (v < HIST_LO) return HIST_LO;
    return v;
  endfunction

  // Derive section coefficients from the cutoff and clear history.
  function automatic void derive_coefs();
    longint unsigned w, w2, cj, ck, lin2, ssq, quad;
    w  = {32'd0, cutoff_reg};
    w2 = w * w;
    w_sq = ((w2 >> 43) + 64'd1) >> 1;
    foreach (hist_y[i]) hist_y[i] = 0;
    for (int s = 0; s < N_SEC; s++) begin
      cj   = POLES[2*s];
      ck   = POLES[2*s+1];
      lin2 = (cj * w + (64'd1 << 42)) >> 43;
      ssq  = (cj * cj + ck * ck + (64'd1 << 29)) >> 30;
      quad = (w_sq * ssq + (64'd1 << 29)) >> 30;
      coef_a[s] = ONE_Q16 + lin2 + quad;
      coef_b[s] = 2 * ONE_Q16 + lin2;
    end
  endfunction

  function automatic void clear_state();
    cutoff_reg = '0;
    foreach (hist_y[i]) hist_y[i] = 0;
    for (int s = 0; s < N_SEC; s++) begin
      coef_a[s] = ONE_Q16;
      coef_b[s] = 2 * ONE_Q16;
    end
    w_sq = 0;
  endfunction

  // Run one beat through the shadow cascade and return the filtered word.
  function automatic logic [31:0] run_cascade(logic [2:0] fn, logic [31:0] smp);
    longint y, num, r;
    int     base;
    if (fn == bwlp8_pkg::FUNC_INIT) begin
      derive_coefs();
      return '0;
    end
    if (int'(fn) - 1 >= N_CH) return '0;
    y = longint'(signed'(smp));
    for (int s = 0; s < N_SEC; s++) begin
      base = ((int'(fn) - 1) * N_SEC + s) * 2;
      num  = longint'(w_sq) * y + longint'(coef_b[s]) * hist_y[base]
           - hist_y[base+1] * 65536;
      r    = clip_hist(num / longint'(coef_a[s]));
      hist_y[base+1] = hist_y[base];
      hist_y[base]   = r;
      y = r;
    end
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    return y[31:0];
  endfunction

  // Offer one beat; tvalid stays high on return so back-to-back beats
  // keep it high across the boundary unless a random idle gap is inserted.
  task automatic send_beat(logic [2:0] fn, logic [31:0] smp);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 13) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = fn;
    s_tdata  = smp;
    do @(posedge clk); while (!s_tready);
    filtered_q.push_back(run_cascade(fn, smp));
  endtask

  // Drop valid, let every result drain, then let the datapath settle.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (filtered_q.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_cutoff(logic [31:0] val);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    cutoff_reg = val;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(2000, 0)) - 1000) << 16;
      3: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_before_init();
    // reset coefficients: everything must stay zero
    for (int c = 1; c <= N_CH; c++) send_beat(3'(c), 32'h7fff_ffff);
    send_beat(3'd1, 32'h8000_0000);
    send_beat(FN_UNUSED_LO, 32'h1234_5678);
    send_beat(FN_UNUSED_HI, 32'hffff_ffff);
  endtask

  task automatic test_corners();
    write_cutoff(32'h0400_0000);
    send_beat(bwlp8_pkg::FUNC_INIT, 32'hdead_beef);
    for (int c = 1; c <= N_CH; c++) send_beat(3'(c), 32'h0001_0000);
    send_beat(3'd2, 32'h7fff_ffff);
    send_beat(3'd2, 32'h7fff_ffff);
    send_beat(3'd3, 32'h8000_0000);
    send_beat(FN_UNUSED_LO, 32'h0);
    send_beat(3'd4, 32'h0);
    // largest cutoff: coefficients at their widest
    write_cutoff(32'hffff_ffff);
    send_beat(bwlp8_pkg::FUNC_INIT, 32'h0);
    send_beat(3'd1, 32'h7fff_ffff);
    send_beat(3'd1, 32'h8000_0000);
    send_beat(3'd1, 32'h7fff_ffff);
    // zero cutoff after init
    write_cutoff(32'h0);
    send_beat(bwlp8_pkg::FUNC_INIT, 32'h0);
    send_beat(3'd1, 32'h7fff_ffff);
    write_cutoff(32'h0000_0001);
    send_beat(bwlp8_pkg::FUNC_INIT, 32'h0);
    send_beat(3'd4, 32'h8000_0000);
  endtask

  task automatic test_backpressure();
    write_cutoff(32'h1000_0000);
    send_beat(bwlp8_pkg::FUNC_INIT, 32'h0);
    calm = 1'b1;
    hold_len = 1500;
    hold_req++;
    for (int i = 0; i < 8; i++) send_beat(3'($urandom_range(N_CH, 1)), $urandom);
    calm = 1'b0;
  endtask

  task automatic test_random_phase(logic [31:0] cutoff, int n, bit quiet);
    logic [2:0] fn;
    write_cutoff(cutoff);
    send_beat(bwlp8_pkg::FUNC_INIT, $urandom);
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(99)) inside
        [0:2]:   fn = bwlp8_pkg::FUNC_INIT;
        [3:6]:   fn = 3'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
        default: fn = 3'($urandom_range(N_CH, 1));
      endcase
      send_beat(fn, pick_sample());
    end
    calm = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int seen_req;
    int hold_cnt;
    seen_req = 0;
    hold_cnt = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        hold_cnt = hold_len;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready = 1'b0;
      end else begin
        m_tready = calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, m_tdata);
        errors++;
      end else begin
        if (m_tdata !== filtered_q[0]) begin
          $display("%0t: filtered mismatch, expected %h actual %h",
                   $time, filtered_q[0], m_tdata);
          errors++;
        end
        void'(filtered_q.pop_front());
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("** butterworth_lowpass_8th_cascade: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    calm = 1'b0;
    hold_req = 0;
    hold_len = 0;
    wdog = 0;
    clear_state();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_before_init();
    test_corners();
    test_backpressure();
    test_random_phase($urandom_range(32'h0800_0000, 32'h0000_1000), 260, 1'b0);
    test_random_phase($urandom, 260, 1'b1);
    test_random_phase(32'hffff_ffff, 260, 1'b0);
    test_random_phase($urandom_range(32'h4000_0000, 32'h0100_0000), 260, 1'b0);

    wait_idle();
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("** butterworth_lowpass_8th_cascade: PASSED **");
    end else begin
      $display("** butterworth_lowpass_8th_cascade: FAILED **");
    end
    $finish;
  end

endmodule
